// ===== design/bei_pkg.sv =====
// shared types, constants and register codes for the battery energy integrator
package bei_pkg;

  localparam int TS_W = 63;
  localparam int ENERGY_W = 63;
  localparam int NET_W = 64;
  localparam int CNT_W = 32;
  localparam int POWER_W = 18;
  localparam int CURRENT_W = 17;
  localparam int CAP_W = 16;
  localparam int GAP_W = 32;
  localparam int PSUM_W = POWER_W + 1;
  localparam int INC_W = PSUM_W + GAP_W;
  localparam int SECS_W = 13;
  localparam int UNITS_W = 53;
  localparam int LIMIT_W = 52;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_CURRENT_THRESHOLD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATTERY_CAPACITY = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_INTERVAL = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_DELTA = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SAVE_INTERVAL = 3'd4;

  localparam logic [CURRENT_W-1:0] RST_CURRENT_THRESHOLD = 17'd500;
  localparam logic [CAP_W-1:0] RST_BATTERY_CAPACITY = 16'd1280;
  localparam logic [GAP_W-1:0] RST_MAX_INTERVAL = 32'd30000000;
  localparam logic [CAP_W-1:0] RST_SAVE_DELTA = 16'd10;
  localparam logic [CNT_W-1:0] RST_SAVE_INTERVAL = 32'd900;

  localparam logic [36:0] UNITS_PER_WH = 37'd72000000000;
  localparam logic [19:0] US_PER_S = 20'd1000000;
  localparam logic [18:0] HALF_SECOND_US = 19'd500000;

  // floor(x / 1e6) as floor((x >> 6) * SEC_RECIP >> SEC_SHIFT) for x below 2^33
  localparam int SEC_PRESHIFT = 6;
  localparam int SEC_SHIFT = 41;
  localparam int SEC_COARSE_W = GAP_W + 1 - SEC_PRESHIFT;
  localparam int SEC_PROD_W = SEC_COARSE_W + 28;
  localparam logic [27:0] SEC_RECIP = 28'd140737489;

  localparam logic FUNC_CALIBRATE = 1'b1;

  typedef enum logic [1:0] {
    ST_INTEGRATED = 2'd0,
    ST_FIRST      = 2'd1,
    ST_REJECTED   = 2'd2,
    ST_CALIBRATED = 2'd3
  } status_t;

  typedef struct packed {
    logic [CURRENT_W-1:0] current_threshold_ma;
    logic [GAP_W-1:0]     max_interval_us;
    logic [UNITS_W-1:0]   capacity_units;
    logic [UNITS_W-1:0]   delta_units;
    logic [LIMIT_W-1:0]   interval_limit_us;
  } cfg_t;

  typedef struct packed {
    status_t           status;
    logic              flow;
    logic [TS_W-1:0]   timestamp;
    logic [INC_W-1:0]  inc;
    logic [SECS_W-1:0] secs;
  } work_t;

  typedef struct packed {
    status_t             status;
    logic                flow;
    logic [TS_W-1:0]     timestamp;
    logic [ENERGY_W-1:0] charge;
    logic [ENERGY_W-1:0] discharge;
    logic [NET_W-1:0]    net;
    logic [ENERGY_W-1:0] battery;
    logic                calibrated;
    logic [CNT_W-1:0]    charge_secs;
    logic [CNT_W-1:0]    discharge_secs;
    logic [CNT_W-1:0]    sample_count;
  } snap_t;

endpackage

// ===== design/battery_energy_integrator_unit.sv =====
// top level of the trapezoidal battery energy integrator
//
// channel  dir  handshake              payload
// in       in   in_valid / in_ready    func, timestamp_us, current_ma, power_dw,
//                                      inverter_run, charge_mode
// out      out  out_valid / out_ready  flow, status, energies, seconds, count, save
// cfg      in   cfg_we, no wait        cfg_index, cfg_data
//
// one beat per cycle sustained while out_ready is high; each result passes through
// six register stages: input, classify, multiply, accumulate, net, result
// synchronous reset clears all stage valids, the sample history and accumulators
// a stage holds while the one after it is full, so empty stages keep taking beats
// while a result waits on out_ready
module battery_energy_integrator_unit (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [bei_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bei_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [bei_pkg::TS_W-1:0]          timestamp_us,
  input  logic [bei_pkg::CURRENT_W-1:0]     current_ma,
  input  logic [bei_pkg::POWER_W-1:0]       power_dw,
  input  logic                              inverter_run,
  input  logic                              charge_mode,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              flow,
  output logic [1:0]                        status,
  output logic [bei_pkg::ENERGY_W-1:0]      charge_energy,
  output logic [bei_pkg::ENERGY_W-1:0]      discharge_energy,
  output logic signed [bei_pkg::NET_W-1:0]  net_energy,
  output logic [bei_pkg::ENERGY_W-1:0]      battery_energy,
  output logic                              capacity_known,
  output logic [bei_pkg::CNT_W-1:0]         charge_seconds,
  output logic [bei_pkg::CNT_W-1:0]         discharge_seconds,
  output logic [bei_pkg::CNT_W-1:0]         sample_count,
  output logic                              save_request
);

  bei_pkg::cfg_t  cfg;
  bei_pkg::work_t work;
  bei_pkg::snap_t snap;
  logic           work_valid;
  logic           work_ready;
  logic           snap_valid;
  logic           snap_ready;

  bei_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bei_front u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .func           (func),
    .timestamp_us   (timestamp_us),
    .current_ma     (current_ma),
    .power_dw       (power_dw),
    .inverter_run   (inverter_run),
    .charge_mode    (charge_mode),
    .work_valid     (work_valid),
    .work_ready     (work_ready),
    .work           (work)
  );

  bei_accum u_accum (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .work_valid (work_valid),
    .work_ready (work_ready),
    .work       (work),
    .snap_valid (snap_valid),
    .snap_ready (snap_ready),
    .snap       (snap)
  );

  bei_save u_save (
    .clk                (clk),
    .rst                (rst),
    .cfg                (cfg),
    .snap_valid         (snap_valid),
    .snap_ready         (snap_ready),
    .snap               (snap),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .flow               (flow),
    .status             (status),
    .charge_energy      (charge_energy),
    .discharge_energy   (discharge_energy),
    .net_energy         (net_energy),
    .battery_energy     (battery_energy),
    .capacity_known     (capacity_known),
    .charge_seconds     (charge_seconds),
    .discharge_seconds  (discharge_seconds),
    .sample_count       (sample_count),
    .save_request       (save_request)
  );

endmodule

// ===== design/bei_cfg.sv =====
// configuration registers and the thresholds derived from them
module bei_cfg (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [bei_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bei_pkg::CFG_DATA_W-1:0]      cfg_data,
  output bei_pkg::cfg_t                       cfg
);

  logic [bei_pkg::CURRENT_W-1:0] current_threshold_ma;
  logic [bei_pkg::CAP_W-1:0]     capacity_wh;
  logic [bei_pkg::GAP_W-1:0]     max_interval_us;
  logic [bei_pkg::CAP_W-1:0]     save_delta_wh;
  logic [bei_pkg::CNT_W-1:0]     save_period_s;
  logic [bei_pkg::UNITS_W-1:0]   capacity_units;
  logic [bei_pkg::UNITS_W-1:0]   delta_units;
  logic [bei_pkg::LIMIT_W-1:0]   interval_limit_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_threshold_ma <= bei_pkg::RST_CURRENT_THRESHOLD;
      capacity_wh          <= bei_pkg::RST_BATTERY_CAPACITY;
      max_interval_us      <= bei_pkg::RST_MAX_INTERVAL;
      save_delta_wh        <= bei_pkg::RST_SAVE_DELTA;
      save_period_s        <= bei_pkg::RST_SAVE_INTERVAL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bei_pkg::CFG_CURRENT_THRESHOLD: begin
          current_threshold_ma <= cfg_data[bei_pkg::CURRENT_W-1:0];
        end
        bei_pkg::CFG_BATTERY_CAPACITY: begin
          capacity_wh <= cfg_data[bei_pkg::CAP_W-1:0];
        end
        bei_pkg::CFG_MAX_INTERVAL: begin
          max_interval_us <= cfg_data[bei_pkg::GAP_W-1:0];
        end
        bei_pkg::CFG_SAVE_DELTA: begin
          save_delta_wh <= cfg_data[bei_pkg::CAP_W-1:0];
        end
        bei_pkg::CFG_SAVE_INTERVAL: begin
          save_period_s <= cfg_data[bei_pkg::CNT_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  // constant-coefficient products, updated in the cycle after the registers
  always_ff @(posedge clk) begin
    capacity_units    <= bei_pkg::UNITS_W'(capacity_wh)
                         * bei_pkg::UNITS_W'(bei_pkg::UNITS_PER_WH);
    delta_units       <= bei_pkg::UNITS_W'(save_delta_wh)
                         * bei_pkg::UNITS_W'(bei_pkg::UNITS_PER_WH);
    interval_limit_us <= bei_pkg::LIMIT_W'(save_period_s)
                         * bei_pkg::LIMIT_W'(bei_pkg::US_PER_S);
  end

  assign cfg.current_threshold_ma = current_threshold_ma;
  assign cfg.max_interval_us      = max_interval_us;
  assign cfg.capacity_units       = capacity_units;
  assign cfg.delta_units          = delta_units;
  assign cfg.interval_limit_us    = interval_limit_us;

endmodule

// ===== design/bei_front.sv =====
// input register, flow and interval classification, energy and seconds products
module bei_front (
  input  logic                              clk,
  input  logic                              rst,
  input  bei_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              func,
  input  logic [bei_pkg::TS_W-1:0]          timestamp_us,
  input  logic [bei_pkg::CURRENT_W-1:0]     current_ma,
  input  logic [bei_pkg::POWER_W-1:0]       power_dw,
  input  logic                              inverter_run,
  input  logic                              charge_mode,
  output logic                              work_valid,
  input  logic                              work_ready,
  output bei_pkg::work_t                    work
);

  // stage 1: input beat
  logic                          v1;
  logic                          func1;
  logic [bei_pkg::TS_W-1:0]      ts1;
  logic [bei_pkg::CURRENT_W-1:0] cur1;
  logic [bei_pkg::POWER_W-1:0]   pw1;
  logic                          inv1;
  logic                          chg1;

  // sample history
  logic                          have_prior;
  logic                          flow_now;
  logic [bei_pkg::TS_W-1:0]      prior_time;
  logic [bei_pkg::POWER_W-1:0]   prior_power;

  // stage 2: classified beat
  logic                          v2;
  bei_pkg::status_t              status2;
  logic                          flow2;
  logic [bei_pkg::TS_W-1:0]      ts2;
  logic [bei_pkg::GAP_W-1:0]     gap2;
  logic [bei_pkg::PSUM_W-1:0]    psum2;

  // stage 3: products
  logic                          v3;

  logic                          rdy2;
  logic                          rdy3;
  logic                          take1;
  logic                          move12;
  logic                          move23;

  logic [bei_pkg::TS_W:0]        gap;
  logic                          gap_ok;
  logic                          flow_calc;
  logic                          flow1;
  bei_pkg::status_t              status1;
  logic [bei_pkg::PSUM_W-1:0]    psum1;

  logic [bei_pkg::GAP_W:0]           rnd;
  logic [bei_pkg::SEC_COARSE_W-1:0]  coarse;
  logic [bei_pkg::SEC_PROD_W-1:0]    secs_prod;
  logic [bei_pkg::INC_W-1:0]         inc_prod;

  assign rdy3     = !v3 || work_ready;
  assign rdy2     = !v2 || rdy3;
  assign in_ready = !v1 || rdy2;
  assign take1    = in_valid && in_ready;
  assign move12   = v1 && rdy2;
  assign move23   = v2 && rdy3;

  always_comb begin
    gap = {1'b0, ts1} - {1'b0, prior_time};
    gap_ok = !gap[bei_pkg::TS_W] && (gap != '0)
             && (gap[bei_pkg::TS_W-1:bei_pkg::GAP_W] == '0)
             && (gap[bei_pkg::GAP_W-1:0] <= cfg.max_interval_us);

    if (cur1 <= cfg.current_threshold_ma) begin
      flow_calc = 1'b0;
    end else if (!inv1) begin
      flow_calc = 1'b1;
    end else begin
      flow_calc = !chg1;
    end

    priority if (func1 == bei_pkg::FUNC_CALIBRATE) begin
      status1 = bei_pkg::ST_CALIBRATED;
    end else if (!have_prior) begin
      status1 = bei_pkg::ST_FIRST;
    end else if (!gap_ok) begin
      status1 = bei_pkg::ST_REJECTED;
    end else begin
      status1 = bei_pkg::ST_INTEGRATED;
    end

    flow1 = (func1 == bei_pkg::FUNC_CALIBRATE) ? flow_now : flow_calc;
    psum1 = {1'b0, prior_power} + {1'b0, pw1};
  end

  // interval seconds rounded half up, and twice the trapezoid area
  always_comb begin
    rnd       = {1'b0, gap2} + (bei_pkg::GAP_W + 1)'(bei_pkg::HALF_SECOND_US);
    coarse    = rnd[bei_pkg::GAP_W:bei_pkg::SEC_PRESHIFT];
    secs_prod = bei_pkg::SEC_PROD_W'(coarse) * bei_pkg::SEC_PROD_W'(bei_pkg::SEC_RECIP);
    inc_prod  = bei_pkg::INC_W'(psum2) * bei_pkg::INC_W'(gap2);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      have_prior  <= 1'b0;
      flow_now    <= 1'b0;
      prior_time  <= '0;
      prior_power <= '0;
    end else begin
      if (in_ready) begin
        v1 <= in_valid;
      end
      if (rdy2) begin
        v2 <= v1;
      end
      if (rdy3) begin
        v3 <= v2;
      end
      if (move12 && (func1 != bei_pkg::FUNC_CALIBRATE)) begin
        have_prior  <= 1'b1;
        flow_now    <= flow_calc;
        prior_time  <= ts1;
        prior_power <= pw1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take1) begin
      func1 <= func;
      ts1   <= timestamp_us;
      cur1  <= current_ma;
      pw1   <= power_dw;
      inv1  <= inverter_run;
      chg1  <= charge_mode;
    end
    if (move12) begin
      status2 <= status1;
      flow2   <= flow1;
      ts2     <= ts1;
      gap2    <= gap[bei_pkg::GAP_W-1:0];
      psum2   <= psum1;
    end
    if (move23) begin
      work.status    <= status2;
      work.flow      <= flow2;
      work.timestamp <= ts2;
      work.inc       <= inc_prod;
      work.secs      <= secs_prod[bei_pkg::SEC_SHIFT+bei_pkg::SECS_W-1:bei_pkg::SEC_SHIFT];
    end
  end

  assign work_valid = v3;

endmodule

// ===== design/bei_accum.sv =====
// saturating energy, seconds and sample accumulators with a net snapshot stage
module bei_accum (
  input  logic             clk,
  input  logic             rst,
  input  bei_pkg::cfg_t    cfg,
  input  logic             work_valid,
  output logic             work_ready,
  input  bei_pkg::work_t   work,
  output logic             snap_valid,
  input  logic             snap_ready,
  output bei_pkg::snap_t   snap
);

  logic [bei_pkg::ENERGY_W-1:0] charge;
  logic [bei_pkg::ENERGY_W-1:0] discharge;
  logic [bei_pkg::ENERGY_W-1:0] battery;
  logic                         calibrated;
  logic [bei_pkg::CNT_W-1:0]    charge_secs;
  logic [bei_pkg::CNT_W-1:0]    discharge_secs;
  logic [bei_pkg::CNT_W-1:0]    sample_count;

  logic [bei_pkg::ENERGY_W-1:0] charge_next;
  logic [bei_pkg::ENERGY_W-1:0] discharge_next;
  logic [bei_pkg::ENERGY_W-1:0] battery_next;
  logic                         calibrated_next;
  logic [bei_pkg::CNT_W-1:0]    charge_secs_next;
  logic [bei_pkg::CNT_W-1:0]    discharge_secs_next;
  logic [bei_pkg::CNT_W-1:0]    sample_count_next;

  logic                         v4;
  bei_pkg::status_t             status4;
  logic                         flow4;
  logic [bei_pkg::TS_W-1:0]     ts4;
  logic                         v5;

  logic                         rdy5;
  logic                         take4;
  logic                         move45;

  logic [bei_pkg::ENERGY_W:0]   charge_sum;
  logic [bei_pkg::ENERGY_W:0]   discharge_sum;
  logic [bei_pkg::ENERGY_W:0]   battery_sum;
  logic [bei_pkg::ENERGY_W:0]   battery_diff;
  logic [bei_pkg::CNT_W:0]      charge_secs_sum;
  logic [bei_pkg::CNT_W:0]      discharge_secs_sum;

  assign rdy5       = !v5 || snap_ready;
  assign work_ready = !v4 || rdy5;
  assign take4      = work_valid && work_ready;
  assign move45     = v4 && rdy5;

  always_comb begin
    charge_sum         = {1'b0, charge} + (bei_pkg::ENERGY_W + 1)'(work.inc);
    discharge_sum      = {1'b0, discharge} + (bei_pkg::ENERGY_W + 1)'(work.inc);
    battery_sum        = {1'b0, battery} + (bei_pkg::ENERGY_W + 1)'(work.inc);
    battery_diff       = {1'b0, battery} - (bei_pkg::ENERGY_W + 1)'(work.inc);
    charge_secs_sum    = {1'b0, charge_secs} + (bei_pkg::CNT_W + 1)'(work.secs);
    discharge_secs_sum = {1'b0, discharge_secs} + (bei_pkg::CNT_W + 1)'(work.secs);

    charge_next         = charge;
    discharge_next      = discharge;
    battery_next        = battery;
    calibrated_next     = calibrated;
    charge_secs_next    = charge_secs;
    discharge_secs_next = discharge_secs;
    sample_count_next   = sample_count;

    unique case (work.status)
      bei_pkg::ST_CALIBRATED: begin
        battery_next    = bei_pkg::ENERGY_W'(cfg.capacity_units);
        calibrated_next = 1'b1;
      end
      bei_pkg::ST_INTEGRATED: begin
        if (work.flow) begin
          charge_next = charge_sum[bei_pkg::ENERGY_W] ? '1 : charge_sum[bei_pkg::ENERGY_W-1:0];
          charge_secs_next = charge_secs_sum[bei_pkg::CNT_W]
                             ? '1 : charge_secs_sum[bei_pkg::CNT_W-1:0];
          if (calibrated) begin
            battery_next = battery_sum[bei_pkg::ENERGY_W]
                           ? '1 : battery_sum[bei_pkg::ENERGY_W-1:0];
          end
        end else begin
          discharge_next = discharge_sum[bei_pkg::ENERGY_W]
                           ? '1 : discharge_sum[bei_pkg::ENERGY_W-1:0];
          discharge_secs_next = discharge_secs_sum[bei_pkg::CNT_W]
                                ? '1 : discharge_secs_sum[bei_pkg::CNT_W-1:0];
          // floors at zero
          if (calibrated) begin
            battery_next = battery_diff[bei_pkg::ENERGY_W]
                           ? '0 : battery_diff[bei_pkg::ENERGY_W-1:0];
          end
        end
        if (sample_count != '1) begin
          sample_count_next = sample_count + 1'b1;
        end
      end
      bei_pkg::ST_FIRST, bei_pkg::ST_REJECTED: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v4             <= 1'b0;
      v5             <= 1'b0;
      charge         <= '0;
      discharge      <= '0;
      battery        <= '0;
      calibrated     <= 1'b0;
      charge_secs    <= '0;
      discharge_secs <= '0;
      sample_count   <= '0;
    end else begin
      if (work_ready) begin
        v4 <= work_valid;
      end
      if (rdy5) begin
        v5 <= v4;
      end
      if (take4) begin
        charge         <= charge_next;
        discharge      <= discharge_next;
        battery        <= battery_next;
        calibrated     <= calibrated_next;
        charge_secs    <= charge_secs_next;
        discharge_secs <= discharge_secs_next;
        sample_count   <= sample_count_next;
      end
    end
  end

  // accumulators hold the stage 4 beat's values until it moves on
  always_ff @(posedge clk) begin
    if (take4) begin
      status4 <= work.status;
      flow4   <= work.flow;
      ts4     <= work.timestamp;
    end
    if (move45) begin
      snap.status         <= status4;
      snap.flow           <= flow4;
      snap.timestamp      <= ts4;
      snap.charge         <= charge;
      snap.discharge      <= discharge;
      snap.net            <= {1'b0, charge} - {1'b0, discharge};
      snap.battery        <= battery;
      snap.calibrated     <= calibrated;
      snap.charge_secs    <= charge_secs;
      snap.discharge_secs <= discharge_secs;
      snap.sample_count   <= sample_count;
    end
  end

  assign snap_valid = v5;

endmodule

// ===== design/bei_save.sv =====
// save decision, save bookkeeping and the result register
module bei_save (
  input  logic                              clk,
  input  logic                              rst,
  input  bei_pkg::cfg_t                     cfg,
  input  logic                              snap_valid,
  output logic                              snap_ready,
  input  bei_pkg::snap_t                    snap,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              flow,
  output logic [1:0]                        status,
  output logic [bei_pkg::ENERGY_W-1:0]      charge_energy,
  output logic [bei_pkg::ENERGY_W-1:0]      discharge_energy,
  output logic signed [bei_pkg::NET_W-1:0]  net_energy,
  output logic [bei_pkg::ENERGY_W-1:0]      battery_energy,
  output logic                              capacity_known,
  output logic [bei_pkg::CNT_W-1:0]         charge_seconds,
  output logic [bei_pkg::CNT_W-1:0]         discharge_seconds,
  output logic [bei_pkg::CNT_W-1:0]         sample_count,
  output logic                              save_request
);

  logic [bei_pkg::TS_W-1:0]         last_save_time;
  logic [bei_pkg::NET_W-1:0]        net_at_last_save;

  logic                             take;
  logic signed [bei_pkg::NET_W:0]   diff;
  logic signed [bei_pkg::NET_W:0]   thr;
  logic                             delta_hit;
  logic [bei_pkg::TS_W:0]           since_save;
  logic                             time_hit;
  logic                             save_now;

  assign snap_ready = !out_valid || out_ready;
  assign take       = snap_valid && snap_ready;

  always_comb begin
    diff = $signed({snap.net[bei_pkg::NET_W-1], snap.net})
           - $signed({net_at_last_save[bei_pkg::NET_W-1], net_at_last_save});
    thr  = $signed((bei_pkg::NET_W + 1)'(cfg.delta_units));
    // magnitude test without forming the absolute value
    delta_hit = (diff >= thr) || (diff <= -thr);

    since_save = {1'b0, snap.timestamp} - {1'b0, last_save_time};
    time_hit   = !since_save[bei_pkg::TS_W]
                 && (since_save[bei_pkg::TS_W-1:0] >= bei_pkg::TS_W'(cfg.interval_limit_us));

    unique case (snap.status)
      bei_pkg::ST_CALIBRATED: save_now = 1'b1;
      bei_pkg::ST_INTEGRATED: save_now = delta_hit || time_hit;
      bei_pkg::ST_FIRST,
      bei_pkg::ST_REJECTED:   save_now = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid        <= 1'b0;
      last_save_time   <= '0;
      net_at_last_save <= '0;
    end else begin
      if (snap_ready) begin
        out_valid <= snap_valid;
      end
      if (take && save_now) begin
        last_save_time   <= snap.timestamp;
        net_at_last_save <= snap.net;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      flow               <= snap.flow;
      status             <= snap.status;
      charge_energy      <= snap.charge;
      discharge_energy   <= snap.discharge;
      net_energy         <= snap.net;
      battery_energy     <= snap.battery;
      capacity_known     <= snap.calibrated;
      charge_seconds     <= snap.charge_secs;
      discharge_seconds  <= snap.discharge_secs;
      sample_count       <= snap.sample_count;
      save_request       <= save_now;
    end
  end

endmodule

// ===== design/bei_checker.sv =====
// port-level checks on the result channel, bound to the top level
module bei_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [1:0]                        status,
  input logic [bei_pkg::ENERGY_W-1:0]      charge_energy,
  input logic [bei_pkg::ENERGY_W-1:0]      discharge_energy,
  input logic signed [bei_pkg::NET_W-1:0]  net_energy,
  input logic                              capacity_known,
  input logic                              save_request
);

  a_reset_clears_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat present right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(net_energy) && $stable(status))
    else $error("stalled result beat changed");

  a_net_is_difference: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> net_energy == ({1'b0, charge_energy} - {1'b0, discharge_energy}))
    else $error("net energy differs from charge minus discharge");

  a_calibration_saves: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == bei_pkg::ST_CALIBRATED) |-> save_request && capacity_known)
    else $error("calibration beat without save or calibrated flag");

  a_no_save_unintegrated: assert property (@(posedge clk) disable iff (rst)
    out_valid && ((status == bei_pkg::ST_FIRST) || (status == bei_pkg::ST_REJECTED))
    |-> !save_request)
    else $error("save requested on a sample that was not integrated");

endmodule

bind battery_energy_integrator_unit bei_checker u_bei_checker (.*);
